### src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define WCF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define WCF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/wcf_pkg.sv
package wcf_pkg;

  localparam int MAX_CHANNELS = 4096;
  localparam int WEIGHT_BITS  = 16;

  localparam int FREQ_W  = 34;
  localparam int WT_W    = 16;
  localparam int KHZ_W   = 25;
  localparam int STAT_W  = 2;
  localparam int START_W = 12;
  localparam int END_W   = 13;
  localparam int CNT_W   = $clog2(MAX_CHANNELS + 1);
  localparam int PROD_W  = FREQ_W + WT_W;
  localparam int PSUM_W  = 62;
  localparam int WSUM_W  = 28;
  localparam int MID_W   = FREQ_W + 1;
  localparam int DIVR_W  = WSUM_W + 10;
  localparam int REM_W   = PSUM_W - KHZ_W;

  localparam logic [WT_W-1:0] WT_MASK = WT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

  localparam int DIV_STEPS = KHZ_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [DIVR_W-1:0] KHZ_DIV = DIVR_W'(1000);
  localparam logic [DIVR_W-1:0] MID_DIV = DIVR_W'(2000);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = END_W;
  localparam logic [CFG_IDX_W-1:0] REG_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_END   = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_START = 2'd1;
  localparam logic [STAT_W-1:0] ST_END   = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd3;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency_hz;
    logic [WT_W-1:0]   weight;
    logic              last_channel;
  } in_item_t;

  typedef struct packed {
    logic [KHZ_W-1:0]  frequency_khz;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic accept_en;
    logic load_div;
    logic div_step;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_fire;
    logic err;
    logic out_busy;
  } dp_stat_t;

endpackage

### src/wcf_ctrl.sv
module wcf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  wcf_pkg::dp_stat_t  stat,
  output wcf_pkg::ctrl_cmd_t cmd
);

  localparam logic [2:0] S_ACC   = 3'd0;
  localparam logic [2:0] S_FIN   = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [wcf_pkg::STEP_W-1:0]   step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      S_ACC: begin
        cmd.accept_en = 1'b1;
        if (stat.last_fire) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        cmd.load_div = 1'b1;
        step_nxt     = '0;
        state_nxt    = stat.err ? S_DONE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == wcf_pkg::STEP_W'(wcf_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = S_ACC;
        end
      end
      default: begin
        state_nxt = S_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_ACC;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

### src/wcf_dp.sv
module wcf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  wcf_pkg::ctrl_cmd_t                  cmd,
  output wcf_pkg::dp_stat_t                   stat,
  input  logic                                in_valid,
  input  wcf_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output wcf_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [wcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wcf_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [wcf_pkg::START_W-1:0] start_r;
  logic [wcf_pkg::END_W-1:0]   end_r;

  logic [wcf_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [wcf_pkg::PROD_W-1:0]  prod_r, prod_nxt;
  logic [wcf_pkg::PSUM_W-1:0]  psum_r, psum_nxt;
  logic [wcf_pkg::WSUM_W-1:0]  wsum_r, wsum_nxt;
  logic [wcf_pkg::FREQ_W-1:0]  sf_r, sf_nxt;
  logic [wcf_pkg::FREQ_W-1:0]  ef_r, ef_nxt;
  logic                        ovf_r, ovf_nxt;

  logic [wcf_pkg::REM_W:0]     rem_r, rem_nxt;
  logic [wcf_pkg::KHZ_W-1:0]   quo_r, quo_nxt;
  logic [wcf_pkg::DIVR_W-1:0]  dvr_r, dvr_nxt;
  logic [wcf_pkg::STAT_W-1:0]  status_r, status_nxt;

  logic                        out_valid_r, out_valid_nxt;
  wcf_pkg::out_item_t          out_data_r, out_data_nxt;

  logic                        fire;
  logic                        ovf_hit;
  logic                        in_range;
  logic [wcf_pkg::WT_W-1:0]    wt_used;
  logic [wcf_pkg::CNT_W-1:0]   start_ext;
  logic [wcf_pkg::CNT_W-1:0]   end_eff;
  logic [wcf_pkg::STAT_W-1:0]  status_c;
  logic [wcf_pkg::MID_W-1:0]   mid_sum;
  logic [wcf_pkg::PSUM_W-1:0]  dividend;
  logic [wcf_pkg::REM_W+1:0]   trial;
  logic                        qbit;

  assign fire      = in_valid && cmd.accept_en;
  assign wt_used   = in_data.weight & wcf_pkg::WT_MASK;
  assign start_ext = wcf_pkg::CNT_W'(start_r);
  assign ovf_hit   = ovf_r || (count_r >= wcf_pkg::CNT_W'(wcf_pkg::MAX_CHANNELS));
  assign in_range  = (count_r >= start_ext) &&
                     ((end_r == '0) || (count_r < wcf_pkg::CNT_W'(end_r)));
  assign end_eff   = (end_r == '0) ? count_r : wcf_pkg::CNT_W'(end_r);
  assign mid_sum   = wcf_pkg::MID_W'(sf_r) + wcf_pkg::MID_W'(ef_r);
  assign dividend  = (wsum_r == '0) ? wcf_pkg::PSUM_W'(mid_sum) : psum_r;
  assign trial     = {rem_r, quo_r[wcf_pkg::KHZ_W-1]};
  assign qbit      = trial >= (wcf_pkg::REM_W+2)'(dvr_r);

  always_comb begin
    if (ovf_r) begin
      status_c = wcf_pkg::ST_OVF;
    end else if (start_ext >= count_r) begin
      status_c = wcf_pkg::ST_START;
    end else if (end_eff > count_r) begin
      status_c = wcf_pkg::ST_END;
    end else begin
      status_c = wcf_pkg::ST_OK;
    end
  end

  assign stat.last_fire = fire && in_data.last_channel;
  assign stat.err       = status_c != wcf_pkg::ST_OK;
  assign stat.out_busy  = out_valid_r && out_stall;

  always_comb begin
    count_nxt = count_r;
    prod_nxt  = '0;
    psum_nxt  = psum_r + wcf_pkg::PSUM_W'(prod_r);
    wsum_nxt  = wsum_r;
    sf_nxt    = sf_r;
    ef_nxt    = ef_r;
    ovf_nxt   = ovf_r;
    if (cmd.finish) begin
      count_nxt = '0;
      psum_nxt  = '0;
      wsum_nxt  = '0;
      sf_nxt    = '0;
      ef_nxt    = '0;
      ovf_nxt   = 1'b0;
    end else if (fire) begin
      if (ovf_hit) begin
        ovf_nxt = 1'b1;
      end else begin
        if (count_r == start_ext) begin
          sf_nxt = in_data.frequency_hz;
        end
        if (((end_r == '0) && in_data.last_channel) ||
            ((end_r != '0) && ((count_r + 1'b1) == wcf_pkg::CNT_W'(end_r)))) begin
          ef_nxt = in_data.frequency_hz;
        end
        if (in_range) begin
          prod_nxt = wcf_pkg::PROD_W'(in_data.frequency_hz) *
                     wcf_pkg::PROD_W'(wt_used);
          wsum_nxt = wsum_r + wcf_pkg::WSUM_W'(wt_used);
        end
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_comb begin
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    dvr_nxt    = dvr_r;
    status_nxt = status_r;
    if (cmd.load_div) begin
      status_nxt = status_c;
      rem_nxt    = (wcf_pkg::REM_W+1)'(dividend[wcf_pkg::PSUM_W-1:wcf_pkg::KHZ_W]);
      quo_nxt    = dividend[wcf_pkg::KHZ_W-1:0];
      dvr_nxt    = (wsum_r == '0) ? wcf_pkg::MID_DIV :
                   wcf_pkg::DIVR_W'(wcf_pkg::DIVR_W'(wsum_r) * wcf_pkg::KHZ_DIV);
    end else if (cmd.div_step) begin
      rem_nxt = qbit ? (wcf_pkg::REM_W+1)'(trial - (wcf_pkg::REM_W+2)'(dvr_r))
                     : (wcf_pkg::REM_W+1)'(trial);
      quo_nxt = {quo_r[wcf_pkg::KHZ_W-2:0], qbit};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (cmd.finish) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.status        = status_r;
      out_data_nxt.frequency_khz = (status_r == wcf_pkg::ST_OK) ? quo_r : '0;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r     <= '0;
      end_r       <= '0;
      count_r     <= '0;
      prod_r      <= '0;
      psum_r      <= '0;
      wsum_r      <= '0;
      sf_r        <= '0;
      ef_r        <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == wcf_pkg::REG_START)) begin
        start_r <= cfg_data[wcf_pkg::START_W-1:0];
      end
      if (cfg_we && (cfg_index == wcf_pkg::REG_END)) begin
        end_r <= cfg_data;
      end
      count_r     <= count_nxt;
      prod_r      <= prod_nxt;
      psum_r      <= psum_nxt;
      wsum_r      <= wsum_nxt;
      sf_r        <= sf_nxt;
      ef_r        <= ef_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dvr_r      <= dvr_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/weighted_channel_frequency_unit.sv
// Weighted center frequency of one integration. Channels arrive one per transaction, one per
// cycle while in_stall is low, and feed a registered frequency-times-weight multiplier
// followed by a 62-bit accumulator. The channel marked last_channel closes the integration:
// the block stalls its input while it drains the multiplier, checks the channel range, loads
// the divider, runs the bit-serial divider that yields one quotient bit per cycle (skipped
// on a failed range check) and loads the result register once the previous result has left
// the output, the earlier steps running meanwhile; then it takes the next integration's first
// channel. The user must write start_channel and end_channel only between integrations; the
// block itself does not enforce it.
module weighted_channel_frequency_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  wcf_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output wcf_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wcf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wcf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  wcf_pkg::ctrl_cmd_t cmd;
  wcf_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;
  assign in_stall  = !cmd.accept_en;

  wcf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  wcf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

### src/wcf_checker.sv
`include "assert_macros.svh"

module wcf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input wcf_pkg::in_item_t                 in_data,
  input logic                              out_valid,
  input logic                              out_stall,
  input wcf_pkg::out_item_t                out_data
);

  logic out_held;
  logic out_err;
  logic khz_zero;
  logic last_in;

  assign out_held = out_valid && out_stall;
  assign out_err  = out_valid && (out_data.status != wcf_pkg::ST_OK);
  assign khz_zero = out_data.frequency_khz == '0;
  assign last_in  = in_valid && !in_stall && in_data.last_channel;

  `WCF_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")

  `WCF_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_data), "stalled result changed")

  `WCF_ASSERT(a_err_zero, out_err |-> khz_zero, "error result carries a frequency")

  `WCF_ASSERT(a_last_stalls, last_in |=> in_stall, "input open right after last channel")

endmodule

bind weighted_channel_frequency_unit wcf_checker u_wcf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
